@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers for the sequencer, compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// condition must never be seen at a rising edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

@@ src/pca_pkg.sv @@
// ----------------------------------------------------------------------------
// pca_pkg
// types, codes and the microcode store of the pid controller
// ----------------------------------------------------------------------------
`default_nettype none

package pca_pkg;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] LAST_STEP  = 4'd12;
  localparam logic [STEP_W-1:0] CLEAR_STEP = 4'd12;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  typedef enum logic [2:0] {
    CFG_PROP_GAIN, CFG_INTEG_GAIN, CFG_DERIV_GAIN, CFG_INTEGRAL_BOUND,
    CFG_OUTPUT_BOUND, CFG_SAMPLE_PERIOD, CFG_INVERSE_PERIOD, CFG_FILTER_WEIGHT
  } cfg_idx_t;

  typedef enum logic [2:0] {A_KP, A_KI, A_KD, A_ERR, A_TMP, A_WINV, A_W} asel_t;
  typedef enum logic [2:0] {B_ERR, B_ACC, B_SP, B_INVP, B_SR, B_TMP} bsel_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_ERR, OP_P, OP_PRE, OP_INTEG, OP_DIFF, OP_SUMI,
    OP_RATE, OP_FILT0, OP_FILT1, OP_OUT, OP_CLEAR
  } op_t;

  typedef enum logic [1:0] {J_NEXT, J_IF_CLEAR, J_END} jump_t;

  typedef enum logic {SQ_IDLE, SQ_RUN} seq_state_t;

  typedef struct packed {
    logic              mul_en;
    asel_t             a;
    bsel_t             b;
    op_t               op;
    jump_t             jc;
    logic [STEP_W-1:0] target;
  } ucw_t;

  typedef struct packed {
    logic en;
    ucw_t w;
  } ctl_t;

  typedef struct packed {
    logic signed [31:0] prop_gain;
    logic signed [31:0] integ_gain;
    logic signed [31:0] deriv_gain;
    logic [30:0]        integral_bound;
    logic [30:0]        output_bound;
    logic [31:0]        sample_period;
    logic [30:0]        inverse_period;
    logic [16:0]        filter_weight;
  } cfg_regs_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               output_clamped;
    logic               integral_held;
  } res_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (!v[65] && (|v[64:31])) r = 32'sh7FFF_FFFF;
    else if (v[65] && !(&v[64:31])) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic ucw_t mk(input logic m, input asel_t a, input bsel_t b,
                              input op_t op, input jump_t jc,
                              input logic [STEP_W-1:0] tgt);
    ucw_t w;
    w.mul_en = m;
    w.a      = a;
    w.b      = b;
    w.op     = op;
    w.jc     = jc;
    w.target = tgt;
    return w;
  endfunction

  // control store: one word per step, product of step n is used in step n+1
  function automatic ucw_t ucode(input logic [STEP_W-1:0] step);
    ucw_t w;
    case (step)
      4'd0:  w = mk(1'b0, A_KP,   B_ERR,  OP_ERR,   J_IF_CLEAR, CLEAR_STEP);
      4'd1:  w = mk(1'b1, A_KP,   B_ERR,  OP_NONE,  J_NEXT, 4'd0);
      4'd2:  w = mk(1'b1, A_KI,   B_ACC,  OP_P,     J_NEXT, 4'd0);
      4'd3:  w = mk(1'b1, A_ERR,  B_SP,   OP_PRE,   J_NEXT, 4'd0);
      4'd4:  w = mk(1'b0, A_KP,   B_ERR,  OP_INTEG, J_NEXT, 4'd0);
      4'd5:  w = mk(1'b1, A_KI,   B_ACC,  OP_DIFF,  J_NEXT, 4'd0);
      4'd6:  w = mk(1'b1, A_TMP,  B_INVP, OP_SUMI,  J_NEXT, 4'd0);
      4'd7:  w = mk(1'b1, A_WINV, B_SR,   OP_RATE,  J_NEXT, 4'd0);
      4'd8:  w = mk(1'b1, A_W,    B_TMP,  OP_FILT0, J_NEXT, 4'd0);
      4'd9:  w = mk(1'b0, A_KP,   B_ERR,  OP_FILT1, J_NEXT, 4'd0);
      4'd10: w = mk(1'b1, A_KD,   B_SR,   OP_NONE,  J_NEXT, 4'd0);
      4'd11: w = mk(1'b0, A_KP,   B_ERR,  OP_OUT,   J_END,  4'd0);
      4'd12: w = mk(1'b0, A_KP,   B_ERR,  OP_CLEAR, J_END,  4'd0);
      default: w = mk(1'b0, A_KP, B_ERR,  OP_NONE,  J_END,  4'd0);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ src/pca_seq.sv @@
// ----------------------------------------------------------------------------
// pca_seq
// step counter and microcode sequencer
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pca_seq import pca_pkg::*; (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_accept,
  input  wire  in_func,
  input  wire  out_busy,
  output ctl_t ctl,
  output logic idle
);

  seq_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              clr_r, clr_nxt;
  ucw_t              cw;
  logic              stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      step_r  <= '0;
      clr_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_comb begin
    cw        = ucode(step_r);
    stall     = (cw.op == OP_OUT) && out_busy;
    state_nxt = state_r;
    step_nxt  = step_r;
    clr_nxt   = clr_r;
    idle      = 1'b0;
    ctl.en    = 1'b0;
    ctl.w     = cw;
    case (state_r)
      SQ_IDLE: begin
        idle = 1'b1;
        if (in_accept) begin
          state_nxt = SQ_RUN;
          step_nxt  = '0;
          clr_nxt   = in_func;
        end
      end
      SQ_RUN: begin
        ctl.en = !stall;
        if (!stall) begin
          case (cw.jc)
            J_NEXT:     step_nxt = step_r + 1'b1;
            J_IF_CLEAR: step_nxt = clr_r ? cw.target : step_r + 1'b1;
            J_END: begin
              step_nxt  = '0;
              state_nxt = SQ_IDLE;
            end
            default:    step_nxt = step_r + 1'b1;
          endcase
        end
      end
      default: state_nxt = SQ_IDLE;
    endcase
  end

  `ASSERT_CLK(a_start, clk, rst_n, in_accept |=> (state_r == SQ_RUN) && (step_r == '0))
  `ASSERT_NEVER(a_step_range, clk, rst_n, step_r > LAST_STEP)
  `ASSERT_CLK(a_stall_hold, clk, rst_n, (state_r == SQ_RUN) && stall |=> $stable(step_r))
  `ASSERT_NEVER(a_no_accept_run, clk, rst_n, in_accept && (state_r == SQ_RUN))

endmodule

`default_nettype wire

@@ src/pca_datapath.sv @@
// ----------------------------------------------------------------------------
// pca_datapath
// shared multiplier, controller state and post-product arithmetic
// ----------------------------------------------------------------------------
`default_nettype none

module pca_datapath import pca_pkg::*; (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_load,
  input  wire signed [31:0]  measured,
  input  wire signed [31:0]  target,
  input  ctl_t               ctl,
  input  cfg_regs_t          cfg,
  output res_t               res,
  output logic               res_load
);

  // controller state
  logic signed [31:0] acc_r, acc_nxt;
  logic signed [31:0] last_err_r, last_err_nxt;
  logic signed [31:0] sr_r, sr_nxt;
  // working registers
  logic signed [31:0] meas_r, targ_r;
  logic signed [31:0] err_r, err_nxt;
  logic signed [31:0] p_r, p_nxt;
  logic signed [31:0] tmp_r, tmp_nxt;
  logic signed [33:0] s_r, s_nxt;
  logic signed [49:0] facc_r, facc_nxt;
  logic               hold_r, hold_nxt;
  logic signed [65:0] prod_r, prod_nxt;

  logic signed [32:0] a_op, b_op;
  logic [16:0]        w, winv;
  logic signed [31:0] q_prod, pre;
  logic signed [32:0] err33, diff33, ob33;
  logic signed [33:0] pre34;
  logic signed [34:0] asum, ib35, ob35, sum35;
  logic signed [50:0] fsum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      last_err_r <= '0;
      sr_r       <= '0;
    end else begin
      acc_r      <= acc_nxt;
      last_err_r <= last_err_nxt;
      sr_r       <= sr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      meas_r <= measured;
      targ_r <= target;
    end
    err_r  <= err_nxt;
    p_r    <= p_nxt;
    tmp_r  <= tmp_nxt;
    s_r    <= s_nxt;
    facc_r <= facc_nxt;
    hold_r <= hold_nxt;
    prod_r <= prod_nxt;
  end

  // multiplier operands
  always_comb begin
    w    = (cfg.filter_weight > ONE_Q16) ? ONE_Q16 : cfg.filter_weight;
    winv = ONE_Q16 - w;
    case (ctl.w.a)
      A_KP:    a_op = 33'(cfg.prop_gain);
      A_KI:    a_op = 33'(cfg.integ_gain);
      A_KD:    a_op = 33'(cfg.deriv_gain);
      A_ERR:   a_op = 33'(err_r);
      A_TMP:   a_op = 33'(tmp_r);
      A_WINV:  a_op = $signed({16'b0, winv});
      A_W:     a_op = $signed({16'b0, w});
      default: a_op = '0;
    endcase
    case (ctl.w.b)
      B_ERR:   b_op = 33'(err_r);
      B_ACC:   b_op = 33'(acc_r);
      B_SP:    b_op = $signed({1'b0, cfg.sample_period});
      B_INVP:  b_op = $signed({2'b0, cfg.inverse_period});
      B_SR:    b_op = 33'(sr_r);
      B_TMP:   b_op = 33'(tmp_r);
      default: b_op = '0;
    endcase
  end

  always_comb begin
    q_prod = sat32(prod_r >>> 16);
    err33  = 33'(targ_r) - 33'(meas_r);
    diff33 = 33'(err_r) - 33'(last_err_r);
    ob33   = $signed({2'b0, cfg.output_bound});
    ob35   = $signed({4'b0, cfg.output_bound});
    ib35   = $signed({4'b0, cfg.integral_bound});
    pre34  = 34'(p_r) + 34'(q_prod);
    pre    = sat32(66'(pre34));
    asum   = 35'(acc_r) + 35'($signed(prod_r[65:32]));
    fsum   = 51'(facc_r) + 51'($signed(prod_r[49:0]));
    sum35  = 35'(s_r) + 35'(q_prod);

    prod_nxt     = ctl.en && ctl.w.mul_en ? 66'(a_op) * 66'(b_op) : prod_r;
    acc_nxt      = acc_r;
    last_err_nxt = last_err_r;
    sr_nxt       = sr_r;
    err_nxt      = err_r;
    p_nxt        = p_r;
    tmp_nxt      = tmp_r;
    s_nxt        = s_r;
    facc_nxt     = facc_r;
    hold_nxt     = hold_r;
    res_load     = 1'b0;
    res.drive          = sum35[31:0];
    res.output_clamped = 1'b0;
    res.integral_held  = hold_r;

    if (sum35 > ob35) begin
      res.drive          = ob35[31:0];
      res.output_clamped = 1'b1;
    end else if (sum35 < -ob35) begin
      res.drive          = 32'(-ob35);
      res.output_clamped = 1'b1;
    end

    if (ctl.en) begin
      case (ctl.w.op)
        OP_ERR:  err_nxt = sat32(66'(err33));
        OP_P:    p_nxt   = q_prod;
        OP_PRE:  hold_nxt = (33'(pre) >= ob33 && err_r > 32'sd0) ||
                            (33'(pre) <= -ob33 && err_r < 32'sd0);
        OP_INTEG: begin
          // integration held while p+i already pushes against the bound
          if (!hold_r) begin
            if (asum > ib35)       acc_nxt = ib35[31:0];
            else if (asum < -ib35) acc_nxt = 32'(-ib35);
            else                   acc_nxt = asum[31:0];
          end
        end
        OP_DIFF:  tmp_nxt  = sat32(66'(diff33));
        OP_SUMI:  s_nxt    = 34'(p_r) + 34'(q_prod);
        OP_RATE:  tmp_nxt  = q_prod;
        OP_FILT0: facc_nxt = prod_r[49:0];
        OP_FILT1: sr_nxt   = sat32(66'(fsum >>> 16));
        OP_OUT: begin
          res_load     = 1'b1;
          last_err_nxt = err_r;
        end
        OP_CLEAR: begin
          acc_nxt      = '0;
          last_err_nxt = '0;
          sr_nxt       = '0;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/pid_conditional_antiwindup.sv @@
// ----------------------------------------------------------------------------
// pid_conditional_antiwindup
// q16.16 pid controller with conditional-integration anti-windup
// ----------------------------------------------------------------------------
// A compute request (tuser 0) takes a measurement and a target and returns one
// drive value with two flags; a clear request (tuser 1) zeroes the integral,
// the last error and the filtered rate and returns nothing. The work runs on
// one shared 33x33 signed multiplier driven by a 13-word microcode store. A
// compute request walks the store up to its output step, a clear jumps from
// the first step to the clear step, and the input side is ready only in idle.
// Drive is registered at the output, so the next request is taken while a
// result waits; the sequencer only pauses on its last step if the previous
// result is still not taken. Configuration writes are taken at any time and
// should only be issued while the block is idle.
`default_nettype none

module pid_conditional_antiwindup import pca_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  // input stream
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [63:0] in_tdata,   // [31:0] measured, [63:32] target
  input  wire         in_tuser,   // [0] func: 0 compute, 1 clear
  // result stream
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,  // [31:0] drive
  output logic [1:0]  out_tuser,  // [0] output_clamped, [1] integral_held
  // configuration writes
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [31:0] cfg_data
);

  cfg_regs_t cfg_r, cfg_nxt;
  res_t      out_r;
  logic      out_valid_r, out_valid_nxt;
  logic      in_accept;
  logic      idle;
  ctl_t      ctl;
  res_t      res;
  logic      res_load;

  assign in_accept = in_tvalid && in_tready;
  assign in_tready = idle;
  assign cfg_ready = 1'b1;

  // register file, written one index per request
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PROP_GAIN:      cfg_nxt.prop_gain      = cfg_data;
        CFG_INTEG_GAIN:     cfg_nxt.integ_gain     = cfg_data;
        CFG_DERIV_GAIN:     cfg_nxt.deriv_gain     = cfg_data;
        CFG_INTEGRAL_BOUND: cfg_nxt.integral_bound = cfg_data[30:0];
        CFG_OUTPUT_BOUND:   cfg_nxt.output_bound   = cfg_data[30:0];
        CFG_SAMPLE_PERIOD:  cfg_nxt.sample_period  = cfg_data;
        CFG_INVERSE_PERIOD: cfg_nxt.inverse_period = cfg_data[30:0];
        CFG_FILTER_WEIGHT:  cfg_nxt.filter_weight  = cfg_data[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain      <= '0;
      cfg_r.integ_gain     <= '0;
      cfg_r.deriv_gain     <= '0;
      cfg_r.integral_bound <= '0;
      cfg_r.output_bound   <= '0;
      cfg_r.sample_period  <= '0;
      cfg_r.inverse_period <= 31'd65536;   // 1.0 in q16.16
      cfg_r.filter_weight  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // sequencer: walks the control store, one word per cycle unless the output stalls it
  pca_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_func   (in_tuser),
    .out_busy  (out_valid_r && !out_tready),
    .ctl       (ctl),
    .idle      (idle)
  );

  // datapath: multiplier, state and saturating arithmetic
  pca_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_load  (in_accept),
    .measured (in_tdata[31:0]),
    .target   (in_tdata[63:32]),
    .ctl      (ctl),
    .cfg      (cfg_r),
    .res      (res),
    .res_load (res_load)
  );

  // output register, loaded only when the slot is free or being emptied
  always_comb begin
    if (res_load)        out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (res_load) out_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.drive;
  assign out_tuser  = {out_r.integral_held, out_r.output_clamped};

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the q16.16 pid controller with anti-windup
// ----------------------------------------------------------------------------
// Compute and clear requests go into the input stream. A cycle-free model of
// the controller in this file predicts each drive value and its two flags when
// a request is accepted. A checker compares every result that leaves the
// block, field by field, with the oldest prediction. Register writes happen
// only while the block is idle, and the run walks through default, directed,
// extreme and random settings. Both sides idle and stall at random, the sink
// also holds off for a long stretch, and the last part streams with no gaps.
`timescale 1ns / 100ps

module tb_top;
  import pca_pkg::*;

  localparam int     Q_ONE       = 65536;
  localparam longint Q_MAX       = 64'sd2147483647;
  localparam longint Q_MIN       = -64'sd2147483648;
  localparam int     SETTLE_CYC  = 20;    // a clear may still be running when drained
  localparam int     LONG_HOLD   = 400;   // sink hold-off, fills the block
  localparam int     STALL_LIMIT = 3000;  // cycles without any handshake

  typedef struct packed {
    logic signed [31:0] drive;
    logic               clamped;
    logic               held;
  } drive_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // [31:0] measured, [63:32] target
  logic        in_tuser;   // [0] func: 0 compute, 1 clear
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] drive
  logic [1:0]  out_tuser;  // [0] output_clamped, [1] integral_held
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_idx_t    cfg_index;
  logic [31:0] cfg_data;

  // predictor copy of the registers
  longint kp, ki, kd, integ_lim, drive_lim, t_samp, inv_t, alpha;
  // predictor copy of the controller state
  longint integ_acc, prev_err, rate_filt;

  drive_t pending_drives[$];
  int     fail_count;
  int     quiet_cycles;
  bit     idle_on;
  bit     long_hold_req;

  pid_conditional_antiwindup uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint clip32(input longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // q16.16 product, floored, saturated
  function automatic longint q16_mul(input longint a, input longint b);
    return clip32((a * b) >>> 16);
  endfunction

  function automatic void write_register(input cfg_idx_t idx, input logic [31:0] d);
    case (idx)
      CFG_PROP_GAIN:      kp        = longint'($signed(d));
      CFG_INTEG_GAIN:     ki        = longint'($signed(d));
      CFG_DERIV_GAIN:     kd        = longint'($signed(d));
      CFG_INTEGRAL_BOUND: integ_lim = longint'({33'd0, d[30:0]});
      CFG_OUTPUT_BOUND:   drive_lim = longint'({33'd0, d[30:0]});
      CFG_SAMPLE_PERIOD:  t_samp    = longint'({32'd0, d});
      CFG_INVERSE_PERIOD: inv_t     = longint'({33'd0, d[30:0]});
      CFG_FILTER_WEIGHT:  alpha     = longint'({47'd0, d[16:0]});
      default: ;
    endcase
  endfunction

  // one control step; returns 0 for a clear, which yields no drive value
  function automatic bit pid_predict(input logic func, input logic signed [31:0] meas,
                                     input logic signed [31:0] tgt, output drive_t res);
    longint err, p_term, i_term, pre, acc, diff, rate, d_term, sum, w;
    bit     hold, clamped;
    res = '0;
    if (func) begin
      integ_acc = 0;
      prev_err  = 0;
      rate_filt = 0;
      return 1'b0;
    end
    err    = clip32(longint'(tgt) - longint'(meas));
    p_term = q16_mul(kp, err);
    i_term = q16_mul(ki, integ_acc);
    pre    = clip32(p_term + i_term);
    // hold integration when p+i already pushes against the bound with the error
    hold   = (pre >= drive_lim && err > 0) || (pre <= -drive_lim && err < 0);
    if (!hold) begin
      acc = integ_acc + ((err * t_samp) >>> 32);
      if (acc > integ_lim) acc = integ_lim;
      else if (acc < -integ_lim) acc = -integ_lim;
      integ_acc = acc;
    end
    diff = clip32(err - prev_err);
    rate = q16_mul(diff, inv_t);
    w    = (alpha > Q_ONE) ? longint'(Q_ONE) : alpha;  // weight above one acts as one
    rate_filt = clip32((((Q_ONE - w) * rate_filt) + (w * rate)) >>> 16);
    i_term  = q16_mul(ki, integ_acc);
    d_term  = q16_mul(kd, rate_filt);
    sum     = p_term + i_term + d_term;
    clamped = 1'b0;
    if (sum > drive_lim) begin
      sum     = drive_lim;
      clamped = 1'b1;
    end else if (sum < -drive_lim) begin
      sum     = -drive_lim;
      clamped = 1'b1;
    end
    prev_err    = err;
    res.drive   = sum[31:0];
    res.clamped = clamped;
    res.held    = hold;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- random values

  // mostly moderate values, with extremes and full-range words mixed in
  function automatic logic signed [31:0] pick_q16();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 2))
          0:       return 32'sh7FFF_FFFF;
          1:       return 32'sh8000_0000;
          default: return 32'sh0000_0000;
        endcase
      end
      1, 2:    return $urandom;
      default: return $urandom_range(0, 26214400) - 13107200;  // within 200.0
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $urandom_range(0, 16 * Q_ONE) - 8 * Q_ONE;           // within 8.0
  endfunction

  function automatic logic [31:0] pick_bound();
    if ($urandom_range(0, 4) == 0) return $urandom;             // top bit dropped
    return $urandom_range(0, 1000 * Q_ONE);
  endfunction

  // ---------------------------------------------------------------- drivers

  // sender: one request, optionally after a random gap
  task automatic send_request(input logic func, input logic signed [31:0] meas,
                              input logic signed [31:0] tgt);
    drive_t res;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {tgt, meas};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (pid_predict(func, meas, tgt, res)) pending_drives.push_back(res);
  endtask

  // stop sending, let every predicted result out and any clear finish
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // write all eight registers, only ever from an idle block
  task automatic set_config(input logic [31:0] kp_v, input logic [31:0] ki_v,
                            input logic [31:0] kd_v, input logic [31:0] ilim_v,
                            input logic [31:0] olim_v, input logic [31:0] ts_v,
                            input logic [31:0] invt_v, input logic [31:0] alpha_v);
    logic [31:0] vals [8];
    vals = '{kp_v, ki_v, kd_v, ilim_v, olim_v, ts_v, invt_v, alpha_v};
    wait_idle();
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      write_register(cfg_idx_t'(i), vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic set_random_config();
    logic [31:0] alpha_v;
    alpha_v = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, Q_ONE);
    set_config(pick_gain(), pick_gain(), pick_gain(), pick_bound(), pick_bound(),
               ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 429496730),
               ($urandom_range(0, 3) == 0) ? $urandom
                                           : $urandom_range(Q_ONE, 100 * Q_ONE),
               alpha_v);
  endtask

  // ---------------------------------------------------------------- tests

  // register reset values: zero bounds and gains give a zero drive
  task automatic test_power_on_defaults();
    send_request(1'b0, 0, Q_ONE);
    send_request(1'b0, 2 * Q_ONE, 0);
    send_request(1'b0, 0, 0);
  endtask

  // plain steps, windup into the output bound, field extremes and a clear
  task automatic test_directed_steps();
    set_config(Q_ONE, Q_ONE / 2, Q_ONE / 4, 10 * Q_ONE, 50 * Q_ONE, 429496730,
               10 * Q_ONE, Q_ONE / 2);
    send_request(1'b0, 0, 0);
    send_request(1'b0, 0, 5 * Q_ONE);
    send_request(1'b0, 0, 5 * Q_ONE);
    send_request(1'b0, 0, 100 * Q_ONE);   // saturates and holds integration
    send_request(1'b0, 0, 100 * Q_ONE);
    send_request(1'b0, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_request(1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_request(1'b0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_request(1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_request(1'b0, Q_ONE, 0);
  endtask

  // weight above one, zero integral bound, zero period, then zero output bound
  task automatic test_special_settings();
    set_config(Q_ONE, Q_ONE / 2, Q_ONE / 4, 0, 50 * Q_ONE, 0, 10 * Q_ONE, 32'h0001_FFFF);
    send_request(1'b0, 0, 3 * Q_ONE);
    send_request(1'b0, 0, -3 * Q_ONE);
    send_request(1'b0, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_request(1'b0, 0, 0);
    set_config(Q_ONE, Q_ONE / 2, Q_ONE / 4, 10 * Q_ONE, 0, 429496730, Q_ONE, Q_ONE);
    send_request(1'b0, 0, Q_ONE);
    send_request(1'b0, 0, -Q_ONE);
    send_request(1'b0, 0, 0);
  endtask

  // sink holds off long enough that the block stops taking requests
  task automatic test_output_backpressure();
    set_random_config();
    long_hold_req = 1'b1;
    for (int i = 0; i < 24; i++)
      send_request(($urandom_range(0, 9) == 0), pick_q16(), pick_q16());
    wait_idle();  // sender pauses until every drive value is back
  endtask

  // several settings, extremes among them, with random gaps on both sides
  task automatic test_random_settings();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: set_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2: set_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 0, 32'h8000_0000, 32'hFFFE_0000);
        default: set_random_config();
      endcase
      for (int i = 0; i < 100; i++)
        send_request(($urandom_range(0, 19) == 0), pick_q16(), pick_q16());
    end
  endtask

  // back-to-back requests, sink always ready
  task automatic test_streaming_tail();
    set_random_config();
    idle_on = 1'b0;
    for (int i = 0; i < 60; i++)
      send_request(($urandom_range(0, 19) == 0), pick_q16(), pick_q16());
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n         <= 1'b0;
    in_tvalid     <= 1'b0;
    in_tdata      <= '0;
    in_tuser      <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_PROP_GAIN;
    cfg_data      <= '0;
    idle_on       = 1'b1;
    long_hold_req = 1'b0;
    fail_count    = 0;
    // predictor starts from the register reset values
    kp = 0; ki = 0; kd = 0; integ_lim = 0; drive_lim = 0; t_samp = 0;
    inv_t = Q_ONE; alpha = 0;
    integ_acc = 0; prev_err = 0; rate_filt = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_power_on_defaults();
    test_directed_steps();
    test_special_settings();
    test_output_backpressure();
    test_random_settings();
    test_streaming_tail();
    wait_idle();

    if (pending_drives.size() != 0) begin
      $error("%0d drive values never arrived", pending_drives.size());
      fail_count++;
    end
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // sink: random stall bursts, one long hold-off on request, none at the end
  initial begin
    out_tready <= 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
        out_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    drive_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_drives.size() == 0) begin
          $error("unexpected drive value %0d", $signed(out_tdata));
          fail_count++;
        end else begin
          want = pending_drives.pop_front();
          if (out_tdata !== want.drive) begin
            $error("drive: expected %0d, got %0d", want.drive, $signed(out_tdata));
            fail_count++;
          end
          if (out_tuser[0] !== want.clamped) begin
            $error("output_clamped: expected %0b, got %0b", want.clamped, out_tuser[0]);
            fail_count++;
          end
          if (out_tuser[1] !== want.held) begin
            $error("integral_held: expected %0b, got %0b", want.held, out_tuser[1]);
            fail_count++;
          end
        end
      end
      // no handshake on any channel for too long means the block is stuck
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else
        quiet_cycles <= quiet_cycles + 1;
    end else begin
      quiet_cycles <= 0;
    end
  end

endmodule
